// ===== hdl/h2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Fraction bits of the fixed-point formats; hue is Q0.F, the rest 1.F.
  localparam int FRAC_BITS = 16;
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * FRAC_BITS + 2;

  typedef logic [FRAC_BITS-1:0] hue_t;
  typedef logic [FX_W-1:0]      fx_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [7:0]           chan_t;

  localparam fx_t ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  // Sixths of the hue circle.
  typedef enum logic [2:0] {
    SEC_RED_YEL   = 3'd0,
    SEC_YEL_GRN   = 3'd1,
    SEC_GRN_CYN   = 3'd2,
    SEC_CYN_BLU   = 3'd3,
    SEC_BLU_MAG   = 3'd4,
    SEC_MAG_RED   = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t sector;
    hue_t    frac;
    fx_t     sat;
    fx_t     val;
  } s1_t;

  typedef struct packed {
    sector_t sector;
    fx_t     fs;
    fx_t     gs;
    fx_t     sat;
    fx_t     val;
  } s2_t;

  typedef struct packed {
    sector_t sector;
    fx_t     val;
    fx_t     p;
    fx_t     q;
    fx_t     t;
  } s3_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Handshake between two pipeline stages.
  typedef struct packed {
    logic valid;
  } fwd_t;

  typedef struct packed {
    logic ready;
  } bwd_t;

  function automatic fx_t clamp_one(input fx_t x);
    clamp_one = (x > ONE_FX) ? ONE_FX : x;
  endfunction

  // Truncated product of two 1.F values, known to stay at or below 1.0.
  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    prod_t prod;
    prod   = prod_t'(a) * prod_t'(b);
    fx_mul = prod[FRAC_BITS +: FX_W];
  endfunction

  // Channel times 256, truncated; the full-scale value saturates at 255.
  function automatic chan_t to_byte(input fx_t x);
    to_byte = x[FRAC_BITS] ? 8'hFF : x[FRAC_BITS-1 -: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/h2r_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface h2r_in_if import h2r_pkg::*; ();
  logic valid;
  logic ready;
  hue_t hue;
  fx_t  saturation;
  fx_t  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface h2r_out_if import h2r_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsv_to_rgb_convert_core.sv =====
// Channel   Direction  Payload                                    Width
// hsv_in    sink       hue Q0.16, saturation 1.16, brightness 1.16  16/17/17
// rgb_out   source     red, green, blue                            8/8/8
//
// One request enters per clock unless a stall on rgb_out has backed up to the input;
// a taken request passes through four register stages, one each for sector split,
// fractional products, channel products and sector selection.
// Reset (synchronous, active high) clears the stage valid bits only.
// A stall on rgb_out ripples back through the stage ready chain; empty stages
// keep accepting, so bubbles close up and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_convert_core import h2r_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  h2r_in_if.sink    hsv_in,
  h2r_out_if.source rgb_out
);

  fwd_t in_fwd;
  bwd_t in_bwd;
  fwd_t s1_fwd;
  bwd_t s1_bwd;
  fwd_t s2_fwd;
  bwd_t s2_bwd;
  fwd_t s3_fwd;
  bwd_t s3_bwd;
  fwd_t out_fwd;
  bwd_t out_bwd;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  rgb_t out_data;

  assign in_fwd.valid  = hsv_in.valid;
  assign hsv_in.ready  = in_bwd.ready;
  assign out_bwd.ready = rgb_out.ready;
  assign rgb_out.valid = out_fwd.valid;
  assign rgb_out.red   = out_data.red;
  assign rgb_out.green = out_data.green;
  assign rgb_out.blue  = out_data.blue;

  // Stage 1: clamp saturation and brightness, multiply hue by six.
  h2r_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .up_fwd     (in_fwd),
    .up_bwd     (in_bwd),
    .hue        (hsv_in.hue),
    .saturation (hsv_in.saturation),
    .brightness (hsv_in.brightness),
    .dn_fwd     (s1_fwd),
    .dn_bwd     (s1_bwd),
    .data       (s1_data)
  );

  // Stage 2: the two saturation terms that depend on the in-sector position.
  h2r_frac_mul u_frac_mul (
    .clk     (clk),
    .rst     (rst),
    .up_fwd  (s1_fwd),
    .up_bwd  (s1_bwd),
    .up_data (s1_data),
    .dn_fwd  (s2_fwd),
    .dn_bwd  (s2_bwd),
    .data    (s2_data)
  );

  // Stage 3: the three scaled channel candidates p, q and t.
  h2r_chan_mul u_chan_mul (
    .clk     (clk),
    .rst     (rst),
    .up_fwd  (s2_fwd),
    .up_bwd  (s2_bwd),
    .up_data (s2_data),
    .dn_fwd  (s3_fwd),
    .dn_bwd  (s3_bwd),
    .data    (s3_data)
  );

  // Stage 4: order the candidates by sector and reduce to bytes. Its
  // register is the output register of the block.
  h2r_select u_select (
    .clk     (clk),
    .rst     (rst),
    .up_fwd  (s3_fwd),
    .up_bwd  (s3_bwd),
    .up_data (s3_data),
    .dn_fwd  (out_fwd),
    .dn_bwd  (out_bwd),
    .data    (out_data)
  );

  // The output is empty right after reset.
  a_reset_empty : assert property (@(posedge clk) rst |=> !rgb_out.valid)
    else $error("output valid after reset");

  // Saturation terms never exceed the clamped saturation.
  a_frac_bound : assert property (@(posedge clk) disable iff (rst)
      s2_fwd.valid |-> (s2_data.fs <= s2_data.sat) && (s2_data.gs <= s2_data.sat)
                       && (s2_data.sat <= ONE_FX))
    else $error("fractional product out of range");

  // Every channel candidate is at most the value itself.
  a_chan_bound : assert property (@(posedge clk) disable iff (rst)
      s3_fwd.valid |-> (s3_data.p <= s3_data.val) && (s3_data.q <= s3_data.val)
                       && (s3_data.t <= s3_data.val) && (s3_data.val <= ONE_FX))
    else $error("channel candidate above value");

endmodule

`default_nettype wire

// ===== hdl/h2r_sector.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_sector import h2r_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fwd_t up_fwd,
  output bwd_t      up_bwd,
  input  wire hue_t hue,
  input  wire fx_t  saturation,
  input  wire fx_t  brightness,
  output fwd_t      dn_fwd,
  input  wire bwd_t dn_bwd,
  output s1_t       data
);

  logic [FRAC_BITS+2:0] h6;
  s1_t                  data_next;

  // Hue times six splits into the sector and the position inside it.
  always_comb begin
    h6 = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
    data_next.sector = sector_t'(h6[FRAC_BITS +: 3]);
    data_next.frac   = h6[FRAC_BITS-1:0];
    data_next.sat    = clamp_one(saturation);
    data_next.val    = clamp_one(brightness);
  end

  assign up_bwd.ready = !dn_fwd.valid || dn_bwd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_fwd.valid <= 1'b0;
    end else if (up_bwd.ready) begin
      dn_fwd.valid <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_bwd.ready && up_fwd.valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h2r_frac_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_frac_mul import h2r_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fwd_t up_fwd,
  output bwd_t      up_bwd,
  input  wire s1_t  up_data,
  output fwd_t      dn_fwd,
  input  wire bwd_t dn_bwd,
  output s2_t       data
);

  s2_t data_next;

  // f*s and (1-f)*s, both truncated before they meet the value.
  always_comb begin
    data_next.sector = up_data.sector;
    data_next.fs     = fx_mul({1'b0, up_data.frac}, up_data.sat);
    data_next.gs     = fx_mul(ONE_FX - {1'b0, up_data.frac}, up_data.sat);
    data_next.sat    = up_data.sat;
    data_next.val    = up_data.val;
  end

  assign up_bwd.ready = !dn_fwd.valid || dn_bwd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_fwd.valid <= 1'b0;
    end else if (up_bwd.ready) begin
      dn_fwd.valid <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_bwd.ready && up_fwd.valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h2r_chan_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_chan_mul import h2r_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fwd_t up_fwd,
  output bwd_t      up_bwd,
  input  wire s2_t  up_data,
  output fwd_t      dn_fwd,
  input  wire bwd_t dn_bwd,
  output s3_t       data
);

  s3_t data_next;

  // p, q and t are the value scaled down by one minus each saturation term.
  always_comb begin
    data_next.sector = up_data.sector;
    data_next.val    = up_data.val;
    data_next.p      = fx_mul(up_data.val, ONE_FX - up_data.sat);
    data_next.q      = fx_mul(up_data.val, ONE_FX - up_data.fs);
    data_next.t      = fx_mul(up_data.val, ONE_FX - up_data.gs);
  end

  assign up_bwd.ready = !dn_fwd.valid || dn_bwd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_fwd.valid <= 1'b0;
    end else if (up_bwd.ready) begin
      dn_fwd.valid <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_bwd.ready && up_fwd.valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h2r_select.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_select import h2r_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fwd_t up_fwd,
  output bwd_t      up_bwd,
  input  wire s3_t  up_data,
  output fwd_t      dn_fwd,
  input  wire bwd_t dn_bwd,
  output rgb_t      data
);

  fx_t  r_fx;
  fx_t  g_fx;
  fx_t  b_fx;
  rgb_t data_next;

  always_comb begin
    unique case (up_data.sector)
      SEC_RED_YEL: begin
        r_fx = up_data.val; g_fx = up_data.t;   b_fx = up_data.p;
      end
      SEC_YEL_GRN: begin
        r_fx = up_data.q;   g_fx = up_data.val; b_fx = up_data.p;
      end
      SEC_GRN_CYN: begin
        r_fx = up_data.p;   g_fx = up_data.val; b_fx = up_data.t;
      end
      SEC_CYN_BLU: begin
        r_fx = up_data.p;   g_fx = up_data.q;   b_fx = up_data.val;
      end
      SEC_BLU_MAG: begin
        r_fx = up_data.t;   g_fx = up_data.p;   b_fx = up_data.val;
      end
      default: begin
        r_fx = up_data.val; g_fx = up_data.p;   b_fx = up_data.q;
      end
    endcase
    data_next.red   = to_byte(r_fx);
    data_next.green = to_byte(g_fx);
    data_next.blue  = to_byte(b_fx);
  end

  assign up_bwd.ready = !dn_fwd.valid || dn_bwd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_fwd.valid <= 1'b0;
    end else if (up_bwd.ready) begin
      dn_fwd.valid <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_bwd.ready && up_fwd.valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire
